@@ sv/tcc_pkg.sv @@
// shared types, codes and constants of the translated code cache
package tcc_pkg;

    // default sizing handed to the top level
    localparam int unsigned BANK_COUNT_DEF  = 16;
    localparam int unsigned HANDLE_BITS_DEF = 32;

    // a region of the guest map is 16 KiB of addresses, one handle each
    localparam int unsigned REGION_BITS = 14;

    // opcodes
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_STORE  = 3'd1;
    localparam logic [2:0] OP_MARK   = 3'd2;
    localparam logic [2:0] OP_HIT    = 3'd3;
    localparam logic [2:0] OP_INVAL  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BANK   = 2'd1;
    localparam logic [1:0] ST_REGION = 2'd2;

    // empty page bounds
    localparam logic [7:0] BOUND_LO_EMPTY = 8'hff;
    localparam logic [7:0] BOUND_HI_EMPTY = 8'h00;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] address;
        logic [8:0]  bank;
        logic [31:0] code_handle;
        logic [15:0] range_end;
        logic [7:0]  page;
    } t_in_item;

    typedef struct packed {
        logic [31:0] found_handle;
        logic        range_hit;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_HIT,
        S_MARK,
        S_INV,
        S_EMIT
    } t_state;

endpackage

@@ sv/translated_code_cache.sv @@
// translated code cache: handle store over the guest map plus upper page source bounds
// lookup and range hit test: a read step (S_LOOK or S_HIT), then S_EMIT; next item taken in S_EMIT
// store, rejected and unused opcodes: straight to S_EMIT, one item per cycle while replies do not stall
// mark range: one S_MARK step per upper page touched, then S_EMIT; invalidate page: S_INV
//   steps (one handle memory write per entry of the page), then S_EMIT
// after reset the handle memory is zeroed one entry a cycle, all (BANK_COUNT+3)*16384 entries
module translated_code_cache #(
    parameter int unsigned BANK_COUNT  = tcc_pkg::BANK_COUNT_DEF,
    parameter int unsigned HANDLE_BITS = tcc_pkg::HANDLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_stall,
    input  tcc_pkg::t_in_item  i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_stall,
    output tcc_pkg::t_out_item o_rsp
);

    // memory map: slot 0/1 upper region, slot 2 fixed region, slot 3+ one per bank
    localparam int unsigned SLOTS  = BANK_COUNT + 3;
    localparam int unsigned SLOT_W = $clog2(SLOTS);
    localparam int unsigned IDX_W  = SLOT_W + tcc_pkg::REGION_BITS;
    localparam int unsigned DEPTH  = SLOTS << tcc_pkg::REGION_BITS;

    tcc_pkg::t_state    r_state, n_state;
    tcc_pkg::t_in_item  r_req, n_req;
    tcc_pkg::t_out_item r_res, n_res;
    tcc_pkg::t_out_item r_rsp, n_rsp;
    logic               r_rsp_valid, n_rsp_valid;
    logic [7:0]         r_page, n_page;
    logic [7:0]         r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_clr, n_clr;

    // handle memory port
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_addr;
    logic [HANDLE_BITS-1:0] mem_wdata;
    logic [HANDLE_BITS-1:0] mem_rdata;

    // page bounds memory, {low, high} per upper page, with a valid bit per page
    logic [15:0]  r_bnd [0:127];
    logic [15:0]  r_bnd_rdata;
    logic [127:0] r_bvalid;
    logic         r_bv_q;
    logic         bnd_we;
    logic [6:0]   bnd_waddr;
    logic [15:0]  bnd_wdata;
    logic [6:0]   bnd_raddr;
    logic         bv_clr;
    logic [6:0]   bv_clr_idx;

    logic             accept;
    logic             slot_free;
    logic             bank_ok;
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0] req_idx;
    logic [7:0]       cur_lo, cur_hi, new_lo, new_hi, cand_lo, cand_hi;
    logic [7:0]       off;

    tcc_handle_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (HANDLE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // handshake
    assign slot_free   = !r_rsp_valid || !i_rsp_stall;
    assign o_req_stall = !((r_state == tcc_pkg::S_IDLE) ||
                           ((r_state == tcc_pkg::S_EMIT) && slot_free));
    assign accept      = i_req_valid && !o_req_stall;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // address decode of the incoming beat
    assign bank_ok = {1'b0, i_req.bank} < 10'(BANK_COUNT);
    always_comb begin
        if (i_req.address[15]) begin
            slot = SLOT_W'(i_req.address[14]);
        end else if (!i_req.address[14]) begin
            slot = SLOT_W'(2);
        end else begin
            slot = SLOT_W'(i_req.bank) + SLOT_W'(3);
        end
    end
    assign req_idx = {slot, i_req.address[tcc_pkg::REGION_BITS-1:0]};

    // current bounds of the page just read, unwritten pages read as empty
    assign cur_lo  = r_bv_q ? r_bnd_rdata[15:8] : tcc_pkg::BOUND_LO_EMPTY;
    assign cur_hi  = r_bv_q ? r_bnd_rdata[7:0]  : tcc_pkg::BOUND_HI_EMPTY;
    assign cand_lo = (r_page == r_req.address[15:8]) ? r_req.address[7:0] : 8'h00;
    assign cand_hi = (r_page == r_req.range_end[15:8]) ? r_req.range_end[7:0] : 8'hff;
    assign new_lo  = (cand_lo < cur_lo) ? cand_lo : cur_lo;
    assign new_hi  = (cand_hi > cur_hi) ? cand_hi : cur_hi;
    assign off     = r_req.address[7:0];

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_res       = r_res;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        n_page      = r_page;
        n_cnt       = r_cnt;
        n_clr       = r_clr;
        mem_we      = 1'b0;
        mem_addr    = '0;
        mem_wdata   = '0;
        bnd_we      = 1'b0;
        bnd_waddr   = r_page[6:0];
        bnd_wdata   = {new_lo, new_hi};
        bnd_raddr   = i_req.address[14:8];
        bv_clr      = 1'b0;
        bv_clr_idx  = i_req.page[6:0];

        unique case (r_state)
            tcc_pkg::S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(DEPTH - 1)) begin
                    n_state = tcc_pkg::S_IDLE;
                end
            end
            tcc_pkg::S_IDLE: begin
            end
            tcc_pkg::S_LOOK: begin
                n_res.found_handle = 32'(mem_rdata);
                n_state            = tcc_pkg::S_EMIT;
            end
            tcc_pkg::S_HIT: begin
                n_res.range_hit = (off >= cur_lo) && (off <= cur_hi);
                n_state         = tcc_pkg::S_EMIT;
            end
            tcc_pkg::S_MARK: begin
                // one page per cycle: write this page, read the next
                bnd_we = 1'b1;
                if (r_page == r_req.range_end[15:8]) begin
                    n_state = tcc_pkg::S_EMIT;
                end else begin
                    n_page    = r_page + 8'd1;
                    bnd_raddr = n_page[6:0];
                end
            end
            tcc_pkg::S_INV: begin
                // zero every handle of the page
                mem_we   = 1'b1;
                mem_addr = {SLOT_W'(r_page[6]), r_page[5:0], r_cnt};
                n_cnt    = r_cnt + 8'd1;
                if (r_cnt == 8'hff) begin
                    n_state = tcc_pkg::S_EMIT;
                end
            end
            tcc_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_rsp       = r_res;
                    n_rsp_valid = 1'b1;
                    n_state     = tcc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcc_pkg::S_IDLE;
            end
        endcase

        // dispatch of an accepted beat
        if (accept) begin
            n_req   = i_req;
            n_res   = '0;
            n_state = tcc_pkg::S_EMIT;
            unique case (i_req.opcode) inside
                tcc_pkg::OP_LOOKUP, tcc_pkg::OP_STORE: begin
                    if (!i_req.address[15] && i_req.address[14] && !bank_ok) begin
                        n_res.status = tcc_pkg::ST_BANK;
                    end else if (i_req.opcode == tcc_pkg::OP_STORE) begin
                        mem_we    = 1'b1;
                        mem_addr  = req_idx;
                        mem_wdata = HANDLE_BITS'(i_req.code_handle);
                    end else begin
                        mem_addr = req_idx;
                        n_state  = tcc_pkg::S_LOOK;
                    end
                end
                tcc_pkg::OP_MARK: begin
                    if (!i_req.address[15]) begin
                        n_res.status = tcc_pkg::ST_REGION;
                    end else if (i_req.range_end[15:8] >= i_req.address[15:8]) begin
                        n_page  = i_req.address[15:8];
                        n_state = tcc_pkg::S_MARK;
                    end
                end
                tcc_pkg::OP_HIT: begin
                    if (!i_req.address[15]) begin
                        n_res.status = tcc_pkg::ST_REGION;
                    end else begin
                        n_state = tcc_pkg::S_HIT;
                    end
                end
                tcc_pkg::OP_INVAL: begin
                    if (!i_req.page[7]) begin
                        n_res.status = tcc_pkg::ST_REGION;
                    end else begin
                        bv_clr  = 1'b1;
                        n_page  = i_req.page;
                        n_cnt   = 8'd0;
                        n_state = tcc_pkg::S_INV;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcc_pkg::S_CLEAR;
            r_rsp_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_clr       <= n_clr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_res  <= n_res;
        r_rsp  <= n_rsp;
        r_page <= n_page;
        r_cnt  <= n_cnt;
    end

    // page bound valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= '0;
            r_bv_q   <= 1'b0;
        end else begin
            r_bv_q <= r_bvalid[bnd_raddr];
            if (bnd_we) begin
                r_bvalid[bnd_waddr] <= 1'b1;
            end
            if (bv_clr) begin
                r_bvalid[bv_clr_idx] <= 1'b0;
            end
        end
    end

    // page bounds memory
    always_ff @(posedge i_clk) begin
        if (bnd_we) begin
            r_bnd[bnd_waddr] <= bnd_wdata;
        end
        r_bnd_rdata <= r_bnd[bnd_raddr];
    end

    // no beat is taken while the handle memory is being zeroed
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcc_pkg::S_CLEAR) |-> o_req_stall)
        else $error("request accepted during clearing pass");

    // an invalidated page has its bound valid bit clear on the next cycle
    a_inval_clears_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.opcode == tcc_pkg::OP_INVAL) && i_req.page[7])
        |=> !r_bvalid[$past(i_req.page[6:0])])
        else $error("page bounds still valid after invalidate");

    // a store finishes at once and goes straight to the result slot
    a_store_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.opcode == tcc_pkg::OP_STORE)) |=> (r_state == tcc_pkg::S_EMIT))
        else $error("store did not complete in one cycle");

endmodule

@@ sv/tcc_handle_mem.sv @@
// single-port handle memory with registered read data
module tcc_handle_mem #(
    parameter int unsigned DEPTH  = 16384,
    parameter int unsigned ADDR_W = 14,
    parameter int unsigned DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ test/translated_code_cache_tb.sv @@
// self-checking testbench of the translated code cache: directed table, then random phases
module translated_code_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // sizing of the instance under test
    localparam int unsigned BANKS       = 16;
    localparam int unsigned HANDLE_BITS = 32;
    localparam int unsigned REGION_SIZE = 16384;
    localparam logic [31:0] HANDLE_MASK = {32{1'b1}} >> (32 - HANDLE_BITS);

    // guest map boundaries
    localparam logic [15:0] BANKED_BASE      = 16'h4000;
    localparam logic [15:0] UPPER_BASE       = 16'h8000;
    localparam logic [7:0]  UPPER_PAGE_FIRST = 8'h80;

    // opcodes the block leaves unused
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // run shape
    localparam int CLEAR_CYCLES     = (BANKS + 3) * REGION_SIZE;
    localparam int WATCHDOG_LIMIT   = 4 * CLEAR_CYCLES;
    localparam int RANDOM_PER_PHASE = 463;
    localparam int HOLD_CYCLES      = 400;
    localparam int TAIL_CYCLES      = 20;
    localparam int HOT_PCS          = 48;
    localparam int HOT_PAGES        = 8;

    typedef struct {
        tcc_pkg::t_in_item  beat;
        bit                 typed;
        tcc_pkg::t_out_item want;
    } t_stim_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_req_valid = 1'b0;
    tcc_pkg::t_in_item  i_req       = '0;
    logic               i_rsp_stall = 1'b0;
    logic               o_req_stall;
    logic               o_rsp_valid;
    tcc_pkg::t_out_item o_rsp;

    // shadow copy of the cache contents
    bit [31:0] fixed_handles  [0:REGION_SIZE-1];
    bit [31:0] banked_handles [0:BANKS*REGION_SIZE-1];
    bit [31:0] upper_handles  [0:32767];
    bit [7:0]  page_lo        [0:127];
    bit [7:0]  page_hi        [0:127];

    tcc_pkg::t_out_item pending_replies[$];
    t_stim_row          directed_rows[$];

    // addresses and pages that the random part keeps coming back to
    logic [15:0] hot_pc   [0:HOT_PCS-1];
    logic [8:0]  hot_bank [0:HOT_PCS-1];
    logic [7:0]  hot_page [0:HOT_PAGES-1];

    int send_pcts [4] = '{0, 51, 0, 33};
    int stall_pcts[4] = '{0, 0, 51, 33};
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int n_errors      = 0;
    int n_checked     = 0;
    int op_count[8]   = '{default: 0};

    translated_code_cache #(
        .BANK_COUNT (BANKS),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic tcc_pkg::t_in_item mk(input logic [2:0] op, input logic [15:0] addr,
                                             input logic [8:0] bank, input logic [31:0] handle,
                                             input logic [15:0] rend, input logic [7:0] pg);
        tcc_pkg::t_in_item b;
        b.opcode      = op;
        b.address     = addr;
        b.bank        = bank;
        b.code_handle = handle;
        b.range_end   = rend;
        b.page        = pg;
        return b;
    endfunction

    function automatic tcc_pkg::t_out_item mk_reply(input logic [31:0] handle, input logic hit,
                                                    input logic [1:0] st);
        tcc_pkg::t_out_item r;
        r.found_handle = handle;
        r.range_hit    = hit;
        r.status       = st;
        return r;
    endfunction

    // expected reply of one beat; updates the shadow contents as the block would
    function automatic tcc_pkg::t_out_item predict_cache_reply(input tcc_pkg::t_in_item b);
        tcc_pkg::t_out_item r;
        logic [6:0] idx;
        logic [7:0] lo;
        logic [7:0] hi;
        int         first_pg;
        int         last_pg;
        int         slot;
        r = '0;
        case (b.opcode)
            tcc_pkg::OP_LOOKUP, tcc_pkg::OP_STORE: begin
                if (b.address < BANKED_BASE) begin
                    slot = int'(b.address[13:0]);
                    if (b.opcode == tcc_pkg::OP_LOOKUP) r.found_handle = fixed_handles[slot];
                    else fixed_handles[slot] = b.code_handle & HANDLE_MASK;
                end else if (b.address < UPPER_BASE) begin
                    slot = int'(b.bank) * REGION_SIZE + int'(b.address[13:0]);
                    if (b.bank >= BANKS) r.status = tcc_pkg::ST_BANK;
                    else if (b.opcode == tcc_pkg::OP_LOOKUP)
                        r.found_handle = banked_handles[slot];
                    else banked_handles[slot] = b.code_handle & HANDLE_MASK;
                end else begin
                    slot = int'(b.address[14:0]);
                    if (b.opcode == tcc_pkg::OP_LOOKUP) r.found_handle = upper_handles[slot];
                    else upper_handles[slot] = b.code_handle & HANDLE_MASK;
                end
            end
            tcc_pkg::OP_MARK: begin
                if (b.address < UPPER_BASE) begin
                    r.status = tcc_pkg::ST_REGION;
                end else begin
                    // widen the bounds of every page in the range, none if end page < start page
                    first_pg = int'(b.address[15:8]);
                    last_pg  = int'(b.range_end[15:8]);
                    for (int p = first_pg; p <= last_pg; p++) begin
                        idx = p[6:0];
                        lo  = (p == first_pg) ? b.address[7:0] : 8'h00;
                        hi  = (p == last_pg) ? b.range_end[7:0] : 8'hff;
                        if (lo < page_lo[idx]) page_lo[idx] = lo;
                        if (hi > page_hi[idx]) page_hi[idx] = hi;
                    end
                end
            end
            tcc_pkg::OP_HIT: begin
                if (b.address < UPPER_BASE) begin
                    r.status = tcc_pkg::ST_REGION;
                end else begin
                    idx = b.address[14:8];
                    r.range_hit = (b.address[7:0] >= page_lo[idx]) &&
                                  (b.address[7:0] <= page_hi[idx]);
                end
            end
            tcc_pkg::OP_INVAL: begin
                if (b.page < UPPER_PAGE_FIRST) begin
                    r.status = tcc_pkg::ST_REGION;
                end else begin
                    idx = b.page[6:0];
                    for (int e = 0; e < 256; e++) upper_handles[{idx, e[7:0]}] = '0;
                    page_lo[idx] = tcc_pkg::BOUND_LO_EMPTY;
                    page_hi[idx] = tcc_pkg::BOUND_HI_EMPTY;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // random beat, mostly aimed at the hot addresses and pages
    function automatic tcc_pkg::t_in_item random_beat();
        tcc_pkg::t_in_item b;
        int       roll;
        int       k;
        int       span_end;
        b.opcode      = tcc_pkg::OP_LOOKUP;
        b.address     = 16'($urandom);
        b.bank        = 9'($urandom);
        b.code_handle = $urandom;
        b.range_end   = 16'($urandom);
        b.page        = 8'($urandom);
        roll = $urandom_range(99);
        k    = $urandom_range(HOT_PCS - 1);
        if (roll < 36) begin
            b.opcode = tcc_pkg::OP_LOOKUP;
            if ($urandom_range(9) != 0) begin
                b.address = hot_pc[k];
                b.bank    = hot_bank[k];
            end
        end else if (roll < 60) begin
            b.opcode  = tcc_pkg::OP_STORE;
            b.address = hot_pc[k];
            b.bank    = hot_bank[k];
            case ($urandom_range(9))
                0: b.code_handle = 32'h0;
                1: b.code_handle = 32'hffff_ffff;
                default: ;
            endcase
        end else if (roll < 72) begin
            b.opcode  = tcc_pkg::OP_MARK;
            b.address = {hot_page[$urandom_range(HOT_PAGES - 1)], 8'($urandom)};
            case ($urandom_range(9))
                0: ;
                1: b.range_end = 16'(b.address - 16'($urandom_range(1, 300)));
                2: b.address = 16'($urandom);
                3: b.range_end = 16'hffff;
                default: begin
                    span_end = int'(b.address) + $urandom_range(400);
                    b.range_end = (span_end > 16'hffff) ? 16'hffff : 16'(span_end);
                end
            endcase
        end else if (roll < 92) begin
            b.opcode = tcc_pkg::OP_HIT;
            if ($urandom_range(99) < 85)
                b.address = {hot_page[$urandom_range(HOT_PAGES - 1)], 8'($urandom)};
        end else if (roll < 95) begin
            b.opcode = tcc_pkg::OP_INVAL;
            if ($urandom_range(9) < 8) b.page = hot_page[$urandom_range(HOT_PAGES - 1)];
        end else if (roll < 97) begin
            case ($urandom_range(2))
                0: b.opcode = OP_SPARE_5;
                1: b.opcode = OP_SPARE_6;
                default: b.opcode = OP_SPARE_7;
            endcase
        end else begin
            b.opcode = 3'($urandom);
        end
        return b;
    endfunction

    task automatic add_row(input tcc_pkg::t_in_item b, input bit typed,
                           input tcc_pkg::t_out_item want);
        t_stim_row row;
        row.beat  = b;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // offer one beat after a random gap, record its expected reply on accept
    task automatic offer(input tcc_pkg::t_in_item b, input bit typed,
                         input tcc_pkg::t_out_item typed_want);
        tcc_pkg::t_out_item want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= b;
        do @(posedge i_clk); while (o_req_stall !== 1'b0);
        want = predict_cache_reply(b);
        if (typed) want = typed_want;
        pending_replies.push_back(want);
        op_count[b.opcode]++;
    endtask

    task automatic wait_replies_drained();
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_reply(input tcc_pkg::t_out_item got);
        tcc_pkg::t_out_item want;
        if (pending_replies.size() == 0) begin
            n_errors++;
            $display("%0t: reply beat with none pending: found_handle %h range_hit %b status %0d",
                     $realtime, got.found_handle, got.range_hit, got.status);
            return;
        end
        want = pending_replies.pop_front();
        n_checked++;
        if (got.found_handle !== want.found_handle) begin
            n_errors++;
            $display("%0t: found_handle expected %h got %h",
                     $realtime, want.found_handle, got.found_handle);
        end
        if (got.range_hit !== want.range_hit) begin
            n_errors++;
            $display("%0t: range_hit expected %b got %b", $realtime, want.range_hit, got.range_hit);
        end
        if (got.status !== want.status) begin
            n_errors++;
            $display("%0t: status expected %0d got %0d", $realtime, want.status, got.status);
        end
    endtask

    // reply side: check accepted beats, stall at random or for a long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid === 1'b1 && !i_rsp_stall) check_reply(o_rsp);
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_stall === 1'b0) || (o_rsp_valid === 1'b1 && !i_rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d replies pending", $realtime,
                     pending_replies.size());
            $display("translated_code_cache_tb: done, errors");
            $finish;
        end
    end

    initial begin
        // shadow contents after reset
        for (int i = 0; i < 128; i++) begin
            page_lo[i] = tcc_pkg::BOUND_LO_EMPTY;
            page_hi[i] = tcc_pkg::BOUND_HI_EMPTY;
        end

        // directed table: region edges, bank limits, page bounds, rejects, spare opcode
        add_row(mk(tcc_pkg::OP_LOOKUP, 16'h0000, 9'd0, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_LOOKUP, 16'hffff, 9'd0, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_STORE, 16'h0000, 9'd0, 32'hffff_ffff, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_LOOKUP, 16'h0000, 9'd0, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'hffff_ffff, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_STORE, 16'h3fff, 9'd0, 32'h0000_0001, 16'h0, 8'h0), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_STORE, 16'h4000, 9'd15, 32'ha5a5_a5a5, 16'h0, 8'h0), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_LOOKUP, 16'h4000, 9'd15, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'ha5a5_a5a5, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_LOOKUP, 16'h4000, 9'd0, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_STORE, 16'h7fff, 9'd16, 32'h5a5a_5a5a, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_BANK));
        add_row(mk(tcc_pkg::OP_LOOKUP, 16'h7fff, 9'd511, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_BANK));
        add_row(mk(tcc_pkg::OP_STORE, 16'hffff, 9'd0, 32'hdead_beef, 16'h0, 8'h0), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_LOOKUP, 16'hffff, 9'd0, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'hdead_beef, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_HIT, 16'h8000, 9'd0, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_MARK, 16'h7fff, 9'd0, 32'h0, 16'h8010, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_REGION));
        add_row(mk(tcc_pkg::OP_MARK, 16'h8110, 9'd0, 32'h0, 16'h80f0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_MARK, 16'h8010, 9'd0, 32'h0, 16'h8220, 8'h0), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_HIT, 16'h800f, 9'd0, 32'h0, 16'h0, 8'h0), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_HIT, 16'h8010, 9'd0, 32'h0, 16'h0, 8'h0), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_HIT, 16'h8221, 9'd0, 32'h0, 16'h0, 8'h0), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_HIT, 16'h7fff, 9'd0, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_REGION));
        add_row(mk(tcc_pkg::OP_MARK, 16'hff00, 9'd0, 32'h0, 16'hffff, 8'h0), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_INVAL, 16'h0000, 9'd0, 32'h0, 16'h0, 8'hff), 1'b0, '0);
        add_row(mk(tcc_pkg::OP_LOOKUP, 16'hffff, 9'd0, 32'h0, 16'h0, 8'h0), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_OK));
        add_row(mk(tcc_pkg::OP_INVAL, 16'h0000, 9'd0, 32'h0, 16'h0, 8'h7f), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_REGION));
        add_row(mk(OP_SPARE_7, 16'hffff, 9'h1ff, 32'hffff_ffff, 16'hffff, 8'hff), 1'b1,
                mk_reply(32'h0, 1'b0, tcc_pkg::ST_OK));

        // hot pages always include both ends of the upper region
        for (int i = 0; i < HOT_PAGES; i++) hot_page[i] = UPPER_PAGE_FIRST | 8'($urandom);
        hot_page[0]             = 8'h80;
        hot_page[HOT_PAGES - 1] = 8'hff;
        for (int i = 0; i < HOT_PCS; i++) begin
            hot_bank[i] = 9'($urandom);
            case (i % 3)
                0: hot_pc[i] = 16'($urandom_range(16'h3fff));
                1: begin
                    hot_pc[i]   = BANKED_BASE | 16'($urandom_range(16'h3fff));
                    hot_bank[i] = ($urandom_range(9) == 0) ? 9'($urandom_range(BANKS, 511))
                                                           : 9'($urandom_range(BANKS - 1));
                end
                default: hot_pc[i] = {hot_page[$urandom_range(HOT_PAGES - 1)], 8'($urandom)};
            endcase
        end

        // reset, then the block clears its stores before taking beats
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        i_req_valid <= 1'b0;
        wait_replies_drained();

        // random phases; the sender pauses for all replies between them
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pcts[ph];
            rsp_stall_pct = stall_pcts[ph];
            // long reply hold-off while beats keep coming, so the input backs up
            if (ph == 0) hold_token <= hold_token + 1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) offer(random_beat(), 1'b0, '0);
            i_req_valid <= 1'b0;
            wait_replies_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            n_errors++;
            $display("%0t: %0d replies never arrived", $realtime, pending_replies.size());
        end

        $display("covered %0d lookups, %0d stores, %0d marks, %0d hit tests, %0d invalidates,",
                 op_count[tcc_pkg::OP_LOOKUP], op_count[tcc_pkg::OP_STORE],
                 op_count[tcc_pkg::OP_MARK], op_count[tcc_pkg::OP_HIT],
                 op_count[tcc_pkg::OP_INVAL]);
        $display("  %0d spare opcodes; %0d replies checked, %0d mismatches",
                 op_count[OP_SPARE_5] + op_count[OP_SPARE_6] + op_count[OP_SPARE_7],
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("translated_code_cache_tb: done, clean");
        end else begin
            $display("translated_code_cache_tb: done, errors");
        end
        $finish;
    end

endmodule
